### hw/rtl/itf_pkg.sv
// shared types, constants and helpers of the integer to text formatter
`timescale 1ns / 1ps

package itf_pkg;

  localparam int ItfValueBits = 64;
  localparam int ItfMaxChars  = 64;
  localparam int ItfQueueDepth = 2;

  localparam int ValueW  = 64;
  localparam int RadixW  = 6;
  localparam int SizeW   = 7;
  localparam int FlagW   = 7;
  localparam int CharW   = 8;
  localparam int StatusW = 2;
  localparam int DigitW  = 6;
  localparam int CntW    = 8;

  localparam int FlagLeft   = 0;
  localparam int FlagPlus   = 1;
  localparam int FlagSpace  = 2;
  localparam int FlagPrefix = 3;
  localparam int FlagZero   = 4;
  localparam int FlagSigned = 5;
  localparam int FlagUpper  = 6;

  localparam logic [RadixW-1:0] MinRadix = 6'd2;
  localparam logic [RadixW-1:0] MaxRadix = 6'd36;
  localparam logic [RadixW-1:0] RadixOct = 6'd8;
  localparam logic [RadixW-1:0] RadixHex = 6'd16;

  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChPlus   = 8'h2b;
  localparam logic [CharW-1:0] ChMinus  = 8'h2d;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChUpperX = 8'h58;
  localparam logic [CharW-1:0] ChLowerX = 8'h78;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusTrunc    = 2'd1,
    StatusBadRadix = 2'd2
  } itf_status_e;

  typedef enum logic [1:0] {
    SignNone,
    SignMinus,
    SignPlus,
    SignSpace
  } itf_sign_e;

  typedef enum logic [1:0] {
    PfxNone,
    PfxOct,
    PfxHex
  } itf_pfx_e;

  typedef struct packed {
    logic                   bad_radix;
    logic [ValueW-1:0]      mag;
    logic [RadixW-1:0]      radix;
    logic [SizeW-1:0]       text_width;
    logic [SizeW-1:0]       min_digits;
    logic                   left;
    logic                   zero_pad;
    logic                   upper;
    itf_sign_e              sign;
    itf_pfx_e               pfx;
  } itf_job_t;

  function automatic logic [CharW-1:0] digit_char(logic [DigitW-1:0] d, logic upper);
    logic [CharW-1:0] dc;
    dc = {2'b00, d};
    if (d < 6'd10) begin
      return ChZero + dc;
    end
    return (upper ? ChUpperA : ChLowerA) + dc - 8'd10;
  endfunction

  function automatic logic [CharW-1:0] sign_char(itf_sign_e s);
    logic [CharW-1:0] c;
    case (s)
      SignMinus: c = ChMinus;
      SignPlus:  c = ChPlus;
      default:   c = ChSpace;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/integer_to_text_formatter_core.sv
// top level of the integer to text formatter
`timescale 1ns / 1ps

// Converts one integer per request into printf-style ASCII text, one
// character per output transfer.
// Input side is a queue: drive the request fields and raise push; the
// request is taken on a clock edge where push is high and full is low.
// Output side is a queue: while empty is low the oldest character sits on
// character_o/last_o/status_o and is taken on an edge with pop high.
// last_o marks the final character of a conversion; status_o is truncation
// on the final character when the text exceeds MAX_CHARS, or bad radix on
// the single character produced for a radix outside 2..36.
// Digits come from a shared divider that retires 8 quotient bits per cycle.
// A two-entry request queue lets new requests be taken while one converts.
// A stalled receiver holds the output register and stops the back end only.
// Reset empties both queues and returns the back end to idle.

module integer_to_text_formatter_core #(
  parameter int MAX_CHARS  = itf_pkg::ItfMaxChars,
  parameter int VALUE_BITS = itf_pkg::ItfValueBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [itf_pkg::ValueW-1:0]  value_i,
  input  logic [itf_pkg::RadixW-1:0]  radix_i,
  input  logic [itf_pkg::SizeW-1:0]   text_width_i,
  input  logic [itf_pkg::SizeW-1:0]   min_digits_i,
  input  logic [itf_pkg::FlagW-1:0]   format_flags_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [itf_pkg::CharW-1:0]   character_o,
  output logic                        last_o,
  output logic [itf_pkg::StatusW-1:0] status_o
);
  import itf_pkg::*;

  itf_job_t front_job;
  itf_job_t queued_job;
  logic     q_wr_en;
  logic     q_empty;
  logic     q_rd_en;

  assign q_wr_en = push & ~full;

  itf_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .value_i        (value_i),
    .radix_i        (radix_i),
    .text_width_i   (text_width_i),
    .min_digits_i   (min_digits_i),
    .format_flags_i (format_flags_i),
    .job_o          (front_job)
  );

  itf_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (q_wr_en),
    .job_i   (front_job),
    .full_o  (full),
    .rd_en_i (q_rd_en),
    .job_o   (queued_job),
    .empty_o (q_empty)
  );

  itf_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_CHARS  (MAX_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (queued_job),
    .job_valid_i (~q_empty),
    .job_pop_o   (q_rd_en),
    .character_o (character_o),
    .last_o      (last_o),
    .status_o    (status_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

### hw/rtl/itf_front.sv
// front end: masks, signs and classifies an incoming conversion request
`timescale 1ns / 1ps

module itf_front #(
  parameter int VALUE_BITS = itf_pkg::ItfValueBits
) (
  input  logic [itf_pkg::ValueW-1:0] value_i,
  input  logic [itf_pkg::RadixW-1:0] radix_i,
  input  logic [itf_pkg::SizeW-1:0]  text_width_i,
  input  logic [itf_pkg::SizeW-1:0]  min_digits_i,
  input  logic [itf_pkg::FlagW-1:0]  format_flags_i,
  output itf_pkg::itf_job_t          job_o
);
  import itf_pkg::*;

  localparam logic [ValueW-1:0] VMask = {ValueW{1'b1}} >> (ValueW - VALUE_BITS);

  logic [ValueW-1:0] raw;
  logic [ValueW-1:0] neg_raw;
  logic              is_signed;
  logic              neg;

  always_comb begin
    raw       = value_i & VMask;
    neg_raw   = (~raw + ValueW'(1)) & VMask;
    is_signed = format_flags_i[FlagSigned];
    neg       = is_signed & raw[VALUE_BITS-1];

    job_o.bad_radix   = (radix_i < MinRadix) || (radix_i > MaxRadix);
    job_o.mag         = neg ? neg_raw : raw;
    job_o.radix       = radix_i;
    job_o.text_width  = text_width_i;
    job_o.min_digits  = min_digits_i;
    job_o.left        = format_flags_i[FlagLeft];
    job_o.zero_pad    = format_flags_i[FlagZero] & ~format_flags_i[FlagLeft];
    job_o.upper       = format_flags_i[FlagUpper];

    if (neg) begin
      job_o.sign = SignMinus;
    end else if (is_signed && format_flags_i[FlagPlus]) begin
      job_o.sign = SignPlus;
    end else if (is_signed && format_flags_i[FlagSpace]) begin
      job_o.sign = SignSpace;
    end else begin
      job_o.sign = SignNone;
    end

    if (format_flags_i[FlagPrefix] && radix_i == RadixHex) begin
      job_o.pfx = PfxHex;
    end else if (format_flags_i[FlagPrefix] && radix_i == RadixOct) begin
      job_o.pfx = PfxOct;
    end else begin
      job_o.pfx = PfxNone;
    end
  end

endmodule

### hw/rtl/itf_job_queue.sv
// short queue of classified requests between front end and back end
`timescale 1ns / 1ps

module itf_job_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  itf_pkg::itf_job_t job_i,
  output logic              full_o,
  input  logic              rd_en_i,
  output itf_pkg::itf_job_t job_o,
  output logic              empty_o
);
  import itf_pkg::*;

  localparam int Depth = ItfQueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

  itf_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### hw/rtl/itf_back.sv
// back end: digit extraction by iterative division, layout and character output
`timescale 1ns / 1ps

module itf_back #(
  parameter int VALUE_BITS = itf_pkg::ItfValueBits,
  parameter int MAX_CHARS  = itf_pkg::ItfMaxChars
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  itf_pkg::itf_job_t           job_i,
  input  logic                        job_valid_i,
  output logic                        job_pop_o,
  output logic [itf_pkg::CharW-1:0]   character_o,
  output logic                        last_o,
  output logic [itf_pkg::StatusW-1:0] status_o,
  output logic                        empty_o,
  input  logic                        pop_i
);
  import itf_pkg::*;

  localparam int DivSteps = (VALUE_BITS + 7) / 8;
  localparam int DivW     = DivSteps * 8;
  localparam int StepW    = (DivSteps > 1) ? $clog2(DivSteps) : 1;
  localparam int NdW      = $clog2(VALUE_BITS + 1);
  localparam int PosW     = $clog2(MAX_CHARS + 1);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StSize,
    StBound,
    StLimit,
    StEmit
  } state_e;

  state_e               state_q, state_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [NdW-1:0]       nd_q, nd_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 out_valid_q, out_valid_d;
  logic [CharW-1:0]     char_q, char_d;
  logic                 last_q, last_d;
  itf_status_e          status_q, status_d;

  itf_job_t             job_q, job_d;
  logic [DivW-1:0]      dv_q, dv_d;
  logic [DigitW-1:0]    rem_q, rem_d;
  logic [DigitW-1:0]    stk_q [VALUE_BITS];
  logic [CntW-1:0]      pad_q, pad_d;
  logic [CntW-1:0]      prec_q, prec_d;
  logic [CntW-1:0]      b1_q, b1_d, b2_q, b2_d, b3_q, b3_d, b5_q, b5_d, b6_q, b6_d;
  logic [CntW-1:0]      total_q, total_d;
  logic [PosW-1:0]      last_pos_q, last_pos_d;
  logic                 trunc_q, trunc_d;

  logic [DigitW-1:0]    r;
  logic [DigitW:0]      t;
  logic [7:0]           qbits;
  logic [DivW-1:0]      dv_next;

  logic [CntW-1:0]      nd_ext, mind_ext, prec, fixed, lead, zfill, trail;
  logic [CntW-1:0]      sg_len, pf_len;
  logic [CntW:0]        slack;
  logic [CntW-1:0]      pe;
  logic [CharW-1:0]     emit_char;
  logic                 emit_digit;
  logic                 is_last;
  logic                 can_load;
  logic                 stk_push, stk_pop;

  assign character_o = char_q;
  assign last_o      = last_q;
  assign status_o    = status_q;
  assign empty_o     = ~out_valid_q;
  assign can_load    = ~out_valid_q | pop_i;

  // eight restoring division steps per cycle
  always_comb begin
    r     = rem_q;
    t     = '0;
    qbits = '0;
    for (int i = 0; i < 8; i++) begin
      t = {r, dv_q[DivW-1-i]};
      if (t >= {1'b0, job_q.radix}) begin
        r            = DigitW'(t - {1'b0, job_q.radix});
        qbits[7-i]   = 1'b1;
      end else begin
        r = t[DigitW-1:0];
      end
    end
    dv_next = (dv_q << 8) | DivW'(qbits);
  end

  // layout arithmetic
  always_comb begin
    nd_ext   = CntW'(nd_q);
    mind_ext = CntW'(job_q.min_digits);
    prec     = (mind_ext > nd_ext) ? mind_ext : nd_ext;
    sg_len   = (job_q.sign != SignNone) ? CntW'(1) : '0;
    case (job_q.pfx)
      PfxHex:  pf_len = CntW'(2);
      PfxOct:  pf_len = CntW'(1);
      default: pf_len = '0;
    endcase
    fixed = sg_len + pf_len;
    slack = (CntW+1)'(job_q.text_width) - (CntW+1)'(fixed) - (CntW+1)'(prec);
    lead  = (!job_q.left && !job_q.zero_pad) ? pad_q : '0;
    zfill = job_q.zero_pad ? pad_q : '0;
    trail = job_q.left ? pad_q : '0;
  end

  // character at the current position
  always_comb begin
    pe         = CntW'(pos_q);
    emit_digit = 1'b0;
    if (pe < b1_q) begin
      emit_char = ChSpace;
    end else if (pe < b2_q) begin
      emit_char = sign_char(job_q.sign);
    end else if (pe < b3_q) begin
      emit_char = (pe == b2_q) ? ChZero : (job_q.upper ? ChUpperX : ChLowerX);
    end else if (pe < b5_q) begin
      emit_char = ChZero;
    end else if (pe < b6_q) begin
      emit_char  = digit_char(stk_q[0], job_q.upper);
      emit_digit = 1'b1;
    end else begin
      emit_char = ChSpace;
    end
    is_last = (pos_q == last_pos_q);
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    nd_d        = nd_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    status_d    = status_q;
    job_d       = job_q;
    dv_d        = dv_q;
    rem_d       = rem_q;
    pad_d       = pad_q;
    prec_d      = prec_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    b3_d        = b3_q;
    b5_d        = b5_q;
    b6_d        = b6_q;
    total_d     = total_q;
    last_pos_d  = last_pos_q;
    trunc_d     = trunc_q;
    job_pop_o   = 1'b0;
    stk_push    = 1'b0;
    stk_pop     = 1'b0;

    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          if (job_i.bad_radix) begin
            if (can_load) begin
              job_pop_o   = 1'b1;
              out_valid_d = 1'b1;
              char_d      = ChNul;
              last_d      = 1'b1;
              status_d    = StatusBadRadix;
            end
          end else begin
            job_pop_o = 1'b1;
            job_d     = job_i;
            dv_d      = job_i.mag[DivW-1:0];
            rem_d     = '0;
            step_d    = '0;
            nd_d      = '0;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        dv_d   = dv_next;
        rem_d  = r;
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) begin
          stk_push = 1'b1;
          nd_d     = nd_q + NdW'(1);
          rem_d    = '0;
          step_d   = '0;
          if (dv_next == '0) begin
            state_d = StSize;
          end
        end
      end
      StSize: begin
        prec_d  = prec;
        pad_d   = slack[CntW] ? '0 : slack[CntW-1:0];
        state_d = StBound;
      end
      StBound: begin
        b1_d    = lead;
        b2_d    = lead + sg_len;
        b3_d    = lead + fixed;
        b5_d    = lead + fixed + zfill + (prec_q - nd_ext);
        b6_d    = lead + fixed + zfill + prec_q;
        total_d = lead + fixed + zfill + prec_q + trail;
        state_d = StLimit;
      end
      StLimit: begin
        trunc_d    = (total_q > CntW'(MAX_CHARS));
        last_pos_d = (total_q > CntW'(MAX_CHARS)) ? PosW'(MAX_CHARS - 1)
                                                  : PosW'(total_q - CntW'(1));
        pos_d      = '0;
        state_d    = StEmit;
      end
      StEmit: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          char_d      = emit_char;
          last_d      = is_last;
          status_d    = (is_last && trunc_q) ? StatusTrunc : StatusOk;
          stk_pop     = emit_digit;
          pos_d       = pos_q + PosW'(1);
          if (is_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      nd_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      status_q    <= StatusOk;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      nd_q        <= nd_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    dv_q       <= dv_d;
    rem_q      <= rem_d;
    pad_q      <= pad_d;
    prec_q     <= prec_d;
    b1_q       <= b1_d;
    b2_q       <= b2_d;
    b3_q       <= b3_d;
    b5_q       <= b5_d;
    b6_q       <= b6_d;
    total_q    <= total_d;
    last_pos_q <= last_pos_d;
    trunc_q    <= trunc_d;
  end

  // digit stack, least significant digit pushed first
  always_ff @(posedge clk_i) begin
    if (stk_push) begin
      stk_q[0] <= r;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (stk_pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

endmodule

### verif/itf_text_check.sv
// checker of the integer to text formatter: predicts characters and compares transfers
`timescale 1ns / 1ps

module itf_text_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        full_i,
  input  logic [itf_pkg::ValueW-1:0]  value_i,
  input  logic [itf_pkg::RadixW-1:0]  radix_i,
  input  logic [itf_pkg::SizeW-1:0]   text_width_i,
  input  logic [itf_pkg::SizeW-1:0]   min_digits_i,
  input  logic [itf_pkg::FlagW-1:0]   format_flags_i,
  input  logic                        empty_i,
  input  logic                        pop_i,
  input  logic [itf_pkg::CharW-1:0]   character_i,
  input  logic                        last_i,
  input  logic [itf_pkg::StatusW-1:0] status_i,
  output int                          errors_o,
  output int                          pending_o
);
  import itf_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    itf_status_e      status;
  } text_char_t;

  text_char_t expected_chars[$];
  text_char_t oldest_char;
  int         mismatch_count;

  task automatic format_integer_text(input logic [ValueW-1:0] value,
                                     input logic [RadixW-1:0] radix,
                                     input logic [SizeW-1:0]  text_width,
                                     input logic [SizeW-1:0]  min_digits,
                                     input logic [FlagW-1:0]  flags_in);
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] base;
    logic [FlagW-1:0]  fl;
    logic [CharW-1:0]  digits [64];
    logic [CharW-1:0]  text_q [$];
    logic [CharW-1:0]  sign_ch;
    logic [CharW-1:0]  pad_ch;
    logic [CharW-1:0]  alpha;
    logic [DigitW-1:0] d;
    logic              has_sign;
    text_char_t        tc;
    int                size;
    int                prec;
    int                nd;
    int                n;
    int                i;
    if (radix < MinRadix || radix > MaxRadix) begin
      tc.ch     = ChNul;
      tc.last   = 1'b1;
      tc.status = StatusBadRadix;
      expected_chars.push_back(tc);
      return;
    end
    fl = flags_in;
    if (fl[FlagLeft]) begin
      fl[FlagZero] = 1'b0;
    end
    pad_ch   = fl[FlagZero] ? ChZero : ChSpace;
    alpha    = fl[FlagUpper] ? ChUpperA : ChLowerA;
    mag      = value;
    size     = text_width;
    prec     = min_digits;
    has_sign = 1'b0;
    sign_ch  = ChSpace;
    if (fl[FlagSigned]) begin
      if (mag[ItfValueBits-1]) begin
        sign_ch  = ChMinus;
        mag      = ~mag + 64'd1;
        has_sign = 1'b1;
        size--;
      end else if (fl[FlagPlus]) begin
        sign_ch  = ChPlus;
        has_sign = 1'b1;
        size--;
      end else if (fl[FlagSpace]) begin
        sign_ch  = ChSpace;
        has_sign = 1'b1;
        size--;
      end
    end
    if (fl[FlagPrefix]) begin
      if (radix == RadixHex) begin
        size -= 2;
      end else if (radix == RadixOct) begin
        size--;
      end
    end
    base = {{(ValueW-RadixW){1'b0}}, radix};
    nd = 0;
    if (mag == '0) begin
      digits[0] = ChZero;
      nd = 1;
    end else begin
      while (mag != '0) begin
        d = DigitW'(mag % base);
        digits[nd] = (d < 6'd10) ? ChZero + {2'b00, d} : alpha + {2'b00, d} - 8'd10;
        nd++;
        mag = mag / base;
      end
    end
    if (nd > prec) begin
      prec = nd;
    end
    size -= prec;
    if (!fl[FlagZero] && !fl[FlagLeft]) begin
      while (size > 0) begin
        text_q.push_back(ChSpace);
        size--;
      end
    end
    if (has_sign) begin
      text_q.push_back(sign_ch);
    end
    if (fl[FlagPrefix]) begin
      if (radix == RadixOct) begin
        text_q.push_back(ChZero);
      end else if (radix == RadixHex) begin
        text_q.push_back(ChZero);
        text_q.push_back(fl[FlagUpper] ? ChUpperX : ChLowerX);
      end
    end
    if (!fl[FlagLeft]) begin
      while (size > 0) begin
        text_q.push_back(pad_ch);
        size--;
      end
    end
    for (i = nd; i < prec; i++) begin
      text_q.push_back(ChZero);
    end
    for (i = nd - 1; i >= 0; i--) begin
      text_q.push_back(digits[i]);
    end
    while (size > 0) begin
      text_q.push_back(ChSpace);
      size--;
    end
    n = (text_q.size() > ItfMaxChars) ? ItfMaxChars : text_q.size();
    for (i = 0; i < n; i++) begin
      tc.ch     = text_q[i];
      tc.last   = (i == n - 1);
      tc.status = (i == n - 1 && text_q.size() > n) ? StatusTrunc : StatusOk;
      expected_chars.push_back(tc);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_i) begin
        format_integer_text(value_i, radix_i, text_width_i, min_digits_i,
                            format_flags_i);
      end
      if (pop_i && !empty_i) begin
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected transfer: ch %02h last %0d status %0d",
                     $realtime, character_i, last_i, status_i);
          end
        end else begin
          oldest_char = expected_chars.pop_front();
          if (oldest_char.ch !== character_i || oldest_char.last !== last_i ||
              oldest_char.status !== status_i) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch: expected ch %02h last %0d status %0d,",
                       $realtime, oldest_char.ch, oldest_char.last, oldest_char.status,
                       " got ch %02h last %0d status %0d",
                       character_i, last_i, status_i);
            end
          end
        end
      end
      errors_o  = mismatch_count;
      pending_o = expected_chars.size();
    end
  end

endmodule

### verif/integer_to_text_formatter_core_tb.sv
// testbench top of the integer to text formatter: stimulus, stalls and verdict
`timescale 1ns / 1ps

module integer_to_text_formatter_core_tb;
  import itf_pkg::*;

  localparam logic [FlagW-1:0] FmtLeft   = 7'(1 << FlagLeft);
  localparam logic [FlagW-1:0] FmtPlus   = 7'(1 << FlagPlus);
  localparam logic [FlagW-1:0] FmtSpace  = 7'(1 << FlagSpace);
  localparam logic [FlagW-1:0] FmtPrefix = 7'(1 << FlagPrefix);
  localparam logic [FlagW-1:0] FmtZero   = 7'(1 << FlagZero);
  localparam logic [FlagW-1:0] FmtSigned = 7'(1 << FlagSigned);
  localparam logic [FlagW-1:0] FmtUpper  = 7'(1 << FlagUpper);

  localparam int RandomItems = 146;
  localparam int HoldCycles  = 800;
  localparam int DrainCycles = 700;
  localparam int StallLimit  = 6000;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [ValueW-1:0]  value_i;
  logic [RadixW-1:0]  radix_i;
  logic [SizeW-1:0]   text_width_i;
  logic [SizeW-1:0]   min_digits_i;
  logic [FlagW-1:0]   format_flags_i;
  logic               empty;
  logic               pop;
  logic [CharW-1:0]   character_o;
  logic               last_o;
  logic [StatusW-1:0] status_o;

  int mismatch_count;
  int pending_count;
  int requests_sent;
  bit sender_steady;

  integer_to_text_formatter_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .value_i        (value_i),
    .radix_i        (radix_i),
    .text_width_i   (text_width_i),
    .min_digits_i   (min_digits_i),
    .format_flags_i (format_flags_i),
    .empty          (empty),
    .pop            (pop),
    .character_o    (character_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

  itf_text_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .value_i        (value_i),
    .radix_i        (radix_i),
    .text_width_i   (text_width_i),
    .min_digits_i   (min_digits_i),
    .format_flags_i (format_flags_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .character_i    (character_o),
    .last_i         (last_o),
    .status_i       (status_o),
    .errors_o       (mismatch_count),
    .pending_o      (pending_count)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = ~clk_i;
  end

  task automatic offer_request(input logic [ValueW-1:0] v, input logic [RadixW-1:0] r,
                               input logic [SizeW-1:0] fw, input logic [SizeW-1:0] md,
                               input logic [FlagW-1:0] fl);
    if (!sender_steady) begin
      while ($urandom_range(99) < 29) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push           <= 1'b1;
    value_i        <= v;
    radix_i        <= r;
    text_width_i   <= fw;
    min_digits_i   <= md;
    format_flags_i <= fl;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    requests_sent++;
  endtask

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && requests_sent >= 40) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (requests_sent >= 100 && requests_sent < 140) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 29);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("integer_to_text_formatter_core verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [ValueW-1:0] v;
    logic [RadixW-1:0] r;
    logic [SizeW-1:0]  fw;
    logic [SizeW-1:0]  md;
    logic [FlagW-1:0]  fl;
    int                n;
    rst_ni         = 1'b0;
    push           = 1'b0;
    value_i        = '0;
    radix_i        = '0;
    text_width_i   = '0;
    min_digits_i   = '0;
    format_flags_i = '0;
    requests_sent  = 0;
    sender_steady  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    offer_request(64'd0, 6'd10, 7'd0, 7'd0, '0);
    offer_request('1, 6'd2, 7'd0, 7'd0, '0);
    offer_request('1, 6'd2, 7'd70, 7'd0, '0);
    offer_request(64'h8000_0000_0000_0000, 6'd10, 7'd0, 7'd0, FmtSigned);
    offer_request('1, RadixHex, 7'd0, 7'd0, FmtSigned | FmtPrefix | FmtUpper);
    offer_request(64'd12345, 6'd10, 7'd8, 7'd0, FmtSigned | FmtPlus | FmtSpace);
    offer_request(64'd12345, 6'd10, 7'd8, 7'd0, FmtSigned | FmtSpace);
    offer_request(64'd12345, 6'd10, 7'd8, 7'd0, FmtPlus | FmtSpace);
    offer_request(64'd0, RadixOct, 7'd0, 7'd0, FmtPrefix);
    offer_request(64'd0, RadixHex, 7'd6, 7'd0, FmtPrefix);
    offer_request(64'hDEAD_BEEF, RadixHex, 7'd20, 7'd0, FmtPrefix | FmtZero | FmtUpper);
    offer_request(64'hDEAD_BEEF, RadixHex, 7'd20, 7'd0, FmtPrefix | FmtZero | FmtLeft);
    offer_request(64'hFFFF_FFFF_FFFF_FFD6, 6'd10, 7'd12, 7'd0, FmtSigned | FmtZero);
    offer_request(64'hFFFF_FFFF_FFFF_FFD6, 6'd10, 7'd12, 7'd5, FmtSigned | FmtLeft);
    offer_request(64'd987654321, 6'd36, 7'd0, 7'd30, FmtUpper);
    offer_request('1, 6'd36, 7'd0, 7'd0, '0);
    offer_request(64'd255, 6'd10, 7'd0, 7'd0, FmtPrefix);
    offer_request(64'd7, 6'd0, 7'd0, 7'd0, '0);
    offer_request(64'd7, 6'd1, 7'd0, 7'd0, '0);
    offer_request(64'd7, 6'd37, 7'd0, 7'd0, '0);
    offer_request(64'd7, 6'd63, 7'd127, 7'd127, 7'd127);
    offer_request(64'd5, 6'd10, 7'd127, 7'd127, 7'd127);
    offer_request(64'h7FFF_FFFF_FFFF_FFFF, 6'd2, 7'd64, 7'd0, FmtSigned | FmtPlus);
    offer_request(64'd1, 6'd2, 7'd0, 7'd64, FmtZero);

    for (n = 0; n < RandomItems; n++) begin
      sender_steady = (n >= 60 && n < 110);
      case ($urandom_range(3))
        0: begin
          v = ValueW'($urandom_range(1000));
        end
        1: begin
          v[31:0]  = $urandom();
          v[63:32] = $urandom();
        end
        2: begin
          v = ValueW'($urandom_range(100000));
          v = ~v + 64'd1;
        end
        default: begin
          v[31:0]  = $urandom();
          v[63:32] = $urandom();
          v = v >> $urandom_range(63);
        end
      endcase
      if ($urandom_range(99) < 6) begin
        r = $urandom_range(1) ? 6'($urandom_range(1)) : 6'($urandom_range(63, 37));
      end else begin
        case ($urandom_range(3))
          0: r = RadixHex;
          1: r = RadixOct;
          2: r = 6'd10;
          default: r = 6'($urandom_range(36, 2));
        endcase
      end
      fw = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(20));
      md = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
      fl = 7'($urandom_range(127));
      offer_request(v, r, fw, md, fl);
    end
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("integer_to_text_formatter_core verification clean");
    end else begin
      $display("integer_to_text_formatter_core verification failed");
    end
    $finish;
  end

endmodule
